@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bdeb_pkg.sv @@
// shared types and constants for the button debounce event buffer
package bdeb_pkg;

	// default sizes
	localparam int NUM_BUTTONS_DEF = 64;
	localparam int EVENT_DEPTH_DEF = 16;

	// fixed field widths
	localparam int LEVELS_W = 64;
	localparam int BUTTON_W = 6;
	localparam int THR_W    = 8;
	localparam int EV_W     = BUTTON_W + 1;

	localparam logic [THR_W-1:0] THR_RESET = 8'd3;

	// input item modes
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// event word: pressed in the top bit, button index below
	typedef struct packed {
		logic                pressed;
		logic [BUTTON_W-1:0] button;
	} bdeb_event_t;

	// scan unit to event buffer
	typedef struct packed {
		logic        push;
		bdeb_event_t ev;
	} bdeb_push_t;

	// event buffer status toward the control
	typedef struct packed {
		logic        hit;
		bdeb_event_t ev;
		logic        full;
	} bdeb_fifo_stat_t;

	// control states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} bdeb_state_t;

endpackage

@@ rtl/button_debounce_event_buffer.sv @@
// button debounce event buffer top level
// Input channel (in_valid / in_stall) takes one word: mode and levels.
//   mode scan: levels hold one bit per button; each button is filtered in
//   index order, one button per clock, and accepted level changes are
//   appended to the event buffer (dropped once it is full).
//   mode pop: returns the oldest unread event, or no event and an empty
//   buffer when everything has been read.
// Output channel (out_valid / out_stall) gives exactly one word per input:
//   event_valid, event_button, event_pressed, any_pressed, buffer_full.
// Sequence: a scan passes through ST_SCAN, where the serial pass over the
//   buttons runs, and then ST_DONE; a pop goes from ST_IDLE straight to
//   ST_DONE. ST_DONE loads the result into the output register and returns
//   to ST_IDLE, and a new word is taken only in ST_IDLE, so the block does
//   not accept the next word before the previous result is registered.
// The output register holds a result while out_stall is high; the block
//   finishes the next word and then waits until that register is free.
// cfg_wr_en / cfg_wr_data write the filter threshold (reset value 3); write
//   it only while the block is idle.
// Reset clears stable levels, counters, the buffer fill state and the
//   output valid; buffer contents are not cleared.
`include "assert_macros.svh"

module button_debounce_event_buffer #(
	parameter int NUM_BUTTONS = bdeb_pkg::NUM_BUTTONS_DEF,
	parameter int EVENT_DEPTH = bdeb_pkg::EVENT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [bdeb_pkg::THR_W-1:0]     cfg_wr_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [bdeb_pkg::LEVELS_W-1:0]  levels,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           event_valid,
	output logic [bdeb_pkg::BUTTON_W-1:0]  event_button,
	output logic                           event_pressed,
	output logic                           any_pressed,
	output logic                           buffer_full
);

	bdeb_pkg::bdeb_state_t     state_q;
	bdeb_pkg::bdeb_state_t     state_nx;
	bdeb_pkg::bdeb_push_t      push;
	bdeb_pkg::bdeb_fifo_stat_t stat;

	logic [bdeb_pkg::THR_W-1:0] thr_q;
	logic                       mode_q;
	logic                       in_acc;
	logic                       scan_start;
	logic                       pop_req;
	logic                       scan_done;
	logic                       scan_any;
	logic                       out_free;
	logic                       out_load;

	logic                          out_valid_q;
	logic                          ev_valid_q;
	logic [bdeb_pkg::BUTTON_W-1:0] ev_button_q;
	logic                          ev_pressed_q;
	logic                          any_q;
	logic                          full_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bdeb_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	assign in_acc     = in_valid && !in_stall;
	assign scan_start = in_acc && (mode == bdeb_pkg::MODE_SCAN);
	assign pop_req    = in_acc && (mode == bdeb_pkg::MODE_POP);
	assign out_free   = !out_valid_q || !out_stall;

	// control state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdeb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and handshake
	always_comb begin
		state_nx = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			bdeb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nx = (mode == bdeb_pkg::MODE_SCAN) ? bdeb_pkg::ST_SCAN
						: bdeb_pkg::ST_DONE;
				end
			end
			bdeb_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_nx = bdeb_pkg::ST_DONE;
				end
			end
			bdeb_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = bdeb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = bdeb_pkg::ST_IDLE;
			end
		endcase
	end

	// mode of the word in flight
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
		end
	end

	bdeb_scan #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.levels     (levels),
		.thr        (thr_q),
		.push       (push),
		.done       (scan_done),
		.any_pressed(scan_any)
	);

	bdeb_fifo #(
		.EVENT_DEPTH(EVENT_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop_req),
		.stat  (stat)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (mode_q == bdeb_pkg::MODE_POP) begin
				ev_valid_q   <= stat.hit;
				ev_button_q  <= stat.ev.button;
				ev_pressed_q <= stat.ev.pressed;
			end else begin
				ev_valid_q   <= 1'b0;
				ev_button_q  <= '0;
				ev_pressed_q <= 1'b0;
			end
			any_q  <= scan_any;
			full_q <= stat.full;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_valid   = ev_valid_q;
	assign event_button  = ev_button_q;
	assign event_pressed = ev_pressed_q;
	assign any_pressed   = any_q;
	assign buffer_full   = full_q;

	`ASSERT_NEXT(a_done_loads, state_q == bdeb_pkg::ST_DONE && out_free, out_valid_q && state_q == bdeb_pkg::ST_IDLE, "finished word did not reach the output register")

endmodule

@@ rtl/bdeb_scan.sv @@
// bit-serial debounce unit: one button per cycle through circulating registers
`include "assert_macros.svh"

module bdeb_scan #(
	parameter int NUM_BUTTONS = bdeb_pkg::NUM_BUTTONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [bdeb_pkg::LEVELS_W-1:0]  levels,
	input  logic [bdeb_pkg::THR_W-1:0]     thr,
	output bdeb_pkg::bdeb_push_t           push,
	output logic                           done,
	output logic                           any_pressed
);

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	logic [NUM_BUTTONS-1:0]         lvl_q;
	logic [NUM_BUTTONS-1:0]         stable_q;
	logic [bdeb_pkg::THR_W-1:0]     cnt_q [NUM_BUTTONS];
	logic [IDX_W-1:0]               idx_q;
	logic                           busy_q;
	logic                           any_acc_q;
	logic                           any_q;

	logic                           lv;
	logic                           diff;
	logic                           flip;
	logic                           new_st;
	logic [bdeb_pkg::THR_W-1:0]     new_cnt;

	// per-button decision at the head of the ring
	always_comb begin
		lv      = lvl_q[0];
		diff    = lv ^ stable_q[0];
		flip    = diff && (cnt_q[0] >= thr);
		new_st  = flip ? lv : stable_q[0];
		if (flip) begin
			new_cnt = '0;
		end else if (diff) begin
			new_cnt = cnt_q[0] + 1'b1;
		end else begin
			new_cnt = cnt_q[0];
		end
	end

	assign done = busy_q && (idx_q == IDX_W'(NUM_BUTTONS - 1));

	// event toward the buffer
	always_comb begin
		push            = '0;
		push.push       = busy_q && flip;
		push.ev.pressed = lv;
		push.ev.button  = bdeb_pkg::BUTTON_W'(idx_q);
	end

	// sequencing of one pass over all buttons
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			any_acc_q <= 1'b0;
			any_q     <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			idx_q     <= '0;
			any_acc_q <= 1'b0;
		end else if (busy_q) begin
			any_acc_q <= any_acc_q | new_st;
			if (done) begin
				busy_q <= 1'b0;
				any_q  <= any_acc_q | new_st;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// stable levels and counters rotate once per pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < NUM_BUTTONS - 1; i++) begin
				stable_q[i] <= stable_q[i+1];
				cnt_q[i]    <= cnt_q[i+1];
			end
			stable_q[NUM_BUTTONS-1] <= new_st;
			cnt_q[NUM_BUTTONS-1]    <= new_cnt;
		end
	end

	// raw levels shift out one bit per cycle while a pass is running
	always_ff @(posedge clk) begin
		if (start) begin
			lvl_q <= levels[NUM_BUTTONS-1:0];
		end else if (busy_q) begin
			for (int i = 0; i < NUM_BUTTONS - 1; i++) begin
				lvl_q[i] <= lvl_q[i+1];
			end
			lvl_q[NUM_BUTTONS-1] <= 1'b0;
		end
	end

	assign any_pressed = any_q;

	`ASSERT_ALWAYS(a_start_idle, !(start && busy_q), "scan started while a pass is running")
	`ASSERT_NEXT(a_done_ends, done, !busy_q, "scan unit still busy after its last button")

endmodule

@@ rtl/bdeb_fifo.sv @@
// event buffer: fill-count store with registered read
`include "assert_macros.svh"

module bdeb_fifo #(
	parameter int EVENT_DEPTH = bdeb_pkg::EVENT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdeb_pkg::bdeb_push_t          push,
	input  logic                          pop,
	output bdeb_pkg::bdeb_fifo_stat_t     stat
);

	localparam int CNT_W = $clog2(EVENT_DEPTH + 1);
	localparam int AW    = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(EVENT_DEPTH);

	bdeb_pkg::bdeb_event_t mem [EVENT_DEPTH];
	bdeb_pkg::bdeb_event_t rd_data_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      rd_q;
	logic                  hit_q;
	logic                  hit;
	logic                  full;

	assign full = (count_q == DEPTH_C);
	assign hit  = (rd_q < count_q);

	// fill count and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
			hit_q   <= 1'b0;
		end else if (pop) begin
			hit_q <= hit;
			if (hit) begin
				rd_q <= rd_q + 1'b1;
			end else begin
				rd_q    <= '0;
				count_q <= '0;
			end
		end else if (push.push && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// storage write, events beyond the depth are dropped
	always_ff @(posedge clk) begin
		if (push.push && !full) begin
			mem[count_q[AW-1:0]] <= push.ev;
		end
	end

	// registered read of the oldest unread event
	always_ff @(posedge clk) begin
		if (pop && hit) begin
			rd_data_q <= mem[rd_q[AW-1:0]];
		end
	end

	always_comb begin
		stat      = '0;
		stat.hit  = hit_q;
		stat.ev   = hit_q ? rd_data_q : '0;
		stat.full = full;
	end

	`ASSERT_ALWAYS(a_cnt_bound, count_q <= DEPTH_C && rd_q <= count_q, "fill count out of range")
	`ASSERT_NEXT(a_drain_clears, pop && !hit, count_q == '0 && rd_q == '0 && !hit_q, "drained pop did not empty the buffer")
	`ASSERT_NEXT(a_pop_advance, pop && hit, rd_q == $past(rd_q) + 1'b1 && hit_q, "pop did not advance the read position")

endmodule
